// File: rtl/core/ansi_color_text_terminal_assert.svh
// assertion macros used by the top-level rtl module
`ifndef ANSI_COLOR_TEXT_TERMINAL_ASSERT_SVH
`define ANSI_COLOR_TEXT_TERMINAL_ASSERT_SVH

// overlapping implication, checked outside reset
`define ACTT_ASSERT_NOW(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ACTT_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// File: rtl/core/actt_pkg.sv
`timescale 1ns / 1ps
package actt_pkg;

  localparam int ROWS_DEF  = 16;
  localparam int COLS_DEF  = 52;
  localparam int EDEPTH_DEF = 15;

  localparam logic [31:0] DEFAULT_COLOR = 32'hFF00FF00;
  localparam logic [31:0] BRIGHT_MASK   = 32'h00555555;
  localparam logic [7:0]  ESC_BYTE      = 8'h1B;
  localparam logic [6:0]  SPACE_CHAR    = 7'h20;
  localparam logic [6:0]  CODE_LIMIT    = 7'd127;

  localparam logic [1:0] PH_BRACKET = 2'd0;
  localparam logic [1:0] PH_DIGITS  = 2'd1;
  localparam logic [1:0] PH_BAD     = 2'd2;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic accept;
    logic exec;
    logic clr_wr;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_scroll;
    logic clr_last;
  } dp_sts_t;

  function automatic logic [31:0] palette(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'hFF000000;
      3'd1: v = 32'hFFCC0000;
      3'd2: v = 32'hFF4E9A06;
      3'd3: v = 32'hFFC4A000;
      3'd4: v = 32'hFF3465A4;
      3'd5: v = 32'hFF75507B;
      3'd6: v = 32'hFF06989A;
      default: v = 32'hFFD3D7CF;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/actt_ctrl.sv
`timescale 1ns / 1ps
module actt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  actt_pkg::dp_sts_t sts,
  output actt_pkg::dp_cmd_t cmd
);
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.is_scroll ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    ov_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;
endmodule

// File: rtl/core/actt_dp.sv
`timescale 1ns / 1ps
module actt_dp #(
  parameter int ROWS   = actt_pkg::ROWS_DEF,
  parameter int COLS   = actt_pkg::COLS_DEF,
  parameter int EDEPTH = actt_pkg::EDEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  actt_pkg::dp_cmd_t cmd,
  output actt_pkg::dp_sts_t sts,
  input  logic              in_op,
  input  logic [7:0]        in_char,
  input  logic [3:0]        in_rrow,
  input  logic [5:0]        in_rcol,
  output logic              o_wrote,
  output logic [6:0]        o_char,
  output logic [31:0]       o_color,
  output logic [3:0]        o_row,
  output logic [5:0]        o_col,
  output logic              o_esc,
  output logic              o_scrolled
);
  localparam int N  = ROWS * COLS;
  localparam int AW = $clog2(N);
  localparam int LW = $clog2(N + 1);
  localparam int RW = $clog2(ROWS + 1);
  localparam int TW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(COLS + 1);
  localparam int EW = $clog2(EDEPTH + 1);

  // screen memory, character in the top bits
  logic [38:0] mem [N];
  logic [38:0] rd_q_r;

  logic          req_op_r;
  logic [7:0]    req_char_r;
  logic [3:0]    req_rrow_r;
  logic [5:0]    req_rcol_r;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [TW-1:0] top_r, top_nxt;
  logic          esc_r, esc_nxt;
  logic [EW-1:0] ecnt_r, ecnt_nxt;
  logic [1:0]    eph_r, eph_nxt;
  logic [6:0]    code_r, code_nxt;
  logic [31:0]   cur_r, cur_nxt;

  logic [AW-1:0] clr_addr_r;
  logic [LW-1:0] clr_left_r;

  logic          res_rd_r, res_ok_r, res_wrote_r, res_scr_r;
  logic [6:0]    res_char_r;
  logic [31:0]   res_color_r;

  logic          do_wr, scroll, rd_ok;
  logic [AW-1:0] cell_addr, rd_addr;

  function automatic logic [AW-1:0] phys_addr(input logic [TW-1:0] top,
                                              input logic [TW-1:0] row,
                                              input logic [CW-1:0] col);
    int s;
    s = int'(top) + int'(row);
    if (s >= ROWS) s = s - ROWS;
    return AW'(s * COLS + int'(col));
  endfunction

  assign rd_ok     = (int'(req_rrow_r) < ROWS) && (int'(req_rcol_r) < COLS);
  assign cell_addr = phys_addr(top_r, TW'(row_r), col_r);
  assign rd_addr   = phys_addr(top_r, TW'(req_rrow_r), CW'(req_rcol_r));

  always_comb begin
    logic [7:0]  c;
    logic        letter;
    logic [10:0] v;
    c        = req_char_r;
    letter   = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    v        = 11'(code_r) * 11'd10 + 11'(c - 8'h30);
    row_nxt  = row_r;
    col_nxt  = col_r;
    top_nxt  = top_r;
    esc_nxt  = esc_r;
    ecnt_nxt = ecnt_r;
    eph_nxt  = eph_r;
    code_nxt = code_r;
    cur_nxt  = cur_r;
    do_wr    = 1'b0;
    scroll   = 1'b0;
    if (req_op_r == actt_pkg::OP_READ) begin
    end else if (esc_r) begin
      if (letter) begin
        if (int'(ecnt_r) < EDEPTH && eph_r == actt_pkg::PH_DIGITS && c == 8'h6D) begin
          if (code_r == 7'd0) cur_nxt = actt_pkg::DEFAULT_COLOR;
          else if (code_r inside {[7'd30:7'd37]})
            cur_nxt = actt_pkg::palette(3'(code_r - 7'd30));
          else if (code_r inside {[7'd90:7'd97]})
            cur_nxt = actt_pkg::palette(3'(code_r - 7'd90)) | actt_pkg::BRIGHT_MASK;
        end
        esc_nxt = 1'b0;
      end else if (int'(ecnt_r) < EDEPTH) begin
        if (ecnt_r == '0) begin
          eph_nxt = (c == 8'h5B) ? actt_pkg::PH_DIGITS : actt_pkg::PH_BAD;
        end else if (eph_r == actt_pkg::PH_DIGITS) begin
          if (c >= 8'h30 && c <= 8'h39) begin
            code_nxt = (v > 11'(actt_pkg::CODE_LIMIT)) ? actt_pkg::CODE_LIMIT : 7'(v);
          end else begin
            eph_nxt = actt_pkg::PH_BAD;
          end
        end
        ecnt_nxt = ecnt_r + 1'b1;
      end
    end else if (c == actt_pkg::ESC_BYTE) begin
      esc_nxt  = 1'b1;
      ecnt_nxt = '0;
      eph_nxt  = actt_pkg::PH_BRACKET;
      code_nxt = '0;
    end else begin
      if (c == 8'h0A || c == 8'h0D) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else if (c >= 8'h20 && c <= 8'h7E) begin
        if (int'(col_r) < COLS && int'(row_r) < ROWS) begin
          do_wr   = 1'b1;
          col_nxt = col_r + 1'b1;
        end
      end
      if (int'(col_nxt) >= COLS) begin
        col_nxt = '0;
        row_nxt = row_nxt + 1'b1;
      end
      if (int'(row_nxt) >= ROWS) begin
        scroll  = 1'b1;
        row_nxt = row_nxt - 1'b1;
        top_nxt = (int'(top_r) == ROWS - 1) ? '0 : top_r + 1'b1;
      end
    end
  end

  assign sts.is_scroll = scroll;
  assign sts.clr_last  = (clr_left_r == LW'(1));

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.clr_wr)
      mem[clr_addr_r] <= {actt_pkg::SPACE_CHAR, actt_pkg::DEFAULT_COLOR};
    else if (cmd.exec && do_wr)
      mem[cell_addr] <= {req_char_r[6:0], cur_r};
    if (cmd.exec && req_op_r == actt_pkg::OP_READ)
      rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      top_r      <= '0;
      esc_r      <= 1'b0;
      ecnt_r     <= '0;
      eph_r      <= actt_pkg::PH_BRACKET;
      code_r     <= '0;
      cur_r      <= actt_pkg::DEFAULT_COLOR;
      clr_addr_r <= '0;
      clr_left_r <= LW'(N);
    end else begin
      if (cmd.exec) begin
        row_r  <= row_nxt;
        col_r  <= col_nxt;
        top_r  <= top_nxt;
        esc_r  <= esc_nxt;
        ecnt_r <= ecnt_nxt;
        eph_r  <= eph_nxt;
        code_r <= code_nxt;
        cur_r  <= cur_nxt;
        if (scroll) begin
          clr_addr_r <= AW'(int'(top_r) * COLS);
          clr_left_r <= LW'(COLS);
        end
      end else if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        clr_left_r <= clr_left_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op_r   <= in_op;
      req_char_r <= in_char;
      req_rrow_r <= in_rrow;
      req_rcol_r <= in_rcol;
    end
    if (cmd.exec) begin
      res_rd_r    <= (req_op_r == actt_pkg::OP_READ);
      res_ok_r    <= rd_ok;
      res_wrote_r <= do_wr;
      res_scr_r   <= scroll;
      res_char_r  <= do_wr ? req_char_r[6:0] : 7'd0;
      res_color_r <= do_wr ? cur_r : 32'd0;
    end
    if (cmd.load_out) begin
      o_wrote    <= res_wrote_r;
      o_char     <= res_rd_r ? (res_ok_r ? rd_q_r[38:32] : 7'd0) : res_char_r;
      o_color    <= res_rd_r ? (res_ok_r ? rd_q_r[31:0] : 32'd0) : res_color_r;
      o_row      <= 4'(row_r);
      o_col      <= 6'(col_r);
      o_esc      <= esc_r;
      o_scrolled <= res_scr_r;
    end
  end
endmodule

// File: rtl/core/ansi_color_text_terminal.sv
`timescale 1ns / 1ps
// character terminal engine with sgr colour selection
// input stream: one request per byte put (in_tuser = 0) or cell read (in_tuser = 1)
// result stream: exactly one result per request, in request order
// a request is taken only in the idle state, one at a time
// out_tvalid rises after an execute state and then a load from the done state
// a put that scrolls first clears the new bottom row in a scroll state
// scrolling moves no data: a row offset register rotates the screen memory
// a new request is taken only after the previous result is loaded for output
// the screen is a single-port-write, single-port-read memory of ROWS*COLS cells
// after reset a clearing pass over all ROWS*COLS cells fills the screen with spaces
// in the default colour; no request is taken during that pass
// the output register holds a result while the receiver stalls; the next request
// is still taken and its result waits until the register frees
`include "ansi_color_text_terminal_assert.svh"
module ansi_color_text_terminal #(
  parameter int ROWS         = actt_pkg::ROWS_DEF,
  parameter int COLS         = actt_pkg::COLS_DEF,
  parameter int ESCAPE_DEPTH = actt_pkg::EDEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // char_code[7:0], read_row[11:8], read_col[17:12], zero fill
  input  logic [23:0] in_tdata,
  // op[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_char[6:0], cell_color[38:7], crsr_row[42:39], crsr_col[48:43],
  // esc_open[49], scrolled[50], zero fill
  output logic [55:0] out_tdata,
  // wrote_cell[0]
  output logic        out_tuser
);
  actt_pkg::dp_cmd_t cmd;
  actt_pkg::dp_sts_t sts;

  logic [6:0]  o_char;
  logic [31:0] o_color;
  logic [3:0]  o_row;
  logic [5:0]  o_col;
  logic        o_esc, o_scrolled;

  // sequencer
  actt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // screen memory, cursor, escape parser and output register
  actt_dp #(
    .ROWS   (ROWS),
    .COLS   (COLS),
    .EDEPTH (ESCAPE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_char    (in_tdata[7:0]),
    .in_rrow    (in_tdata[11:8]),
    .in_rcol    (in_tdata[17:12]),
    .o_wrote    (out_tuser),
    .o_char     (o_char),
    .o_color    (o_color),
    .o_row      (o_row),
    .o_col      (o_col),
    .o_esc      (o_esc),
    .o_scrolled (o_scrolled)
  );

  assign out_tdata = {5'd0, o_scrolled, o_esc, o_col, o_row, o_color, o_char};

  // one request in flight: ready drops right after an accept
  `ACTT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // a result is loaded only when the output register is free or draining
  `ACTT_ASSERT_NOW(a_load_free, clk, rst_n, cmd.load_out, !out_tvalid || out_tready)
  // the cursor column shown never reaches the column limit
  `ACTT_ASSERT_NOW(a_col_range, clk, rst_n, out_tvalid, int'(o_col) < COLS)
endmodule

// File: sim/terminal_checker.sv
`timescale 1ns / 1ps
module terminal_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending
);
  localparam int ROWS = actt_pkg::ROWS_DEF;
  localparam int COLS = actt_pkg::COLS_DEF;
  localparam int EDEPTH = actt_pkg::EDEPTH_DEF;

  typedef struct packed {
    logic        wrote;
    logic [6:0]  ch;
    logic [31:0] color;
    logic [3:0]  row;
    logic [5:0]  col;
    logic        esc;
    logic        scrolled;
  } cell_result_t;

  logic [6:0]  scr_char [ROWS*COLS];
  logic [31:0] scr_color [ROWS*COLS];
  int          cur_row, cur_col, esc_count, code;
  logic        esc_on;
  logic [1:0]  esc_phase;
  logic [31:0] pen;
  cell_result_t awaited [$];

  assign pending = awaited.size();

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [31:0] sgr_colour(input int n, input logic [31:0] old);
    if (n == 0) return actt_pkg::DEFAULT_COLOR;
    if (n >= 30 && n <= 37) return actt_pkg::palette(3'(n - 30));
    if (n >= 90 && n <= 97) return actt_pkg::palette(3'(n - 90)) | actt_pkg::BRIGHT_MASK;
    return old;
  endfunction

  // advance the screen model by one request and return what it should produce
  function automatic cell_result_t apply_request(input logic op, input logic [7:0] c,
                                                 input int rr, input int rc);
    cell_result_t r;
    int v;
    r = '0;
    if (op == actt_pkg::OP_READ) begin
      if (rr < ROWS && rc < COLS) begin
        r.ch = scr_char[rr*COLS+rc];
        r.color = scr_color[rr*COLS+rc];
      end
    end else if (esc_on) begin
      if (is_letter(c)) begin
        if (esc_count < EDEPTH && esc_phase == actt_pkg::PH_DIGITS && c == "m")
          pen = sgr_colour(code, pen);
        esc_on = 0;
      end else if (esc_count < EDEPTH) begin
        if (esc_count == 0)
          esc_phase = (c == "[") ? actt_pkg::PH_DIGITS : actt_pkg::PH_BAD;
        else if (esc_phase == actt_pkg::PH_DIGITS) begin
          if (c >= "0" && c <= "9") begin
            v = code * 10 + (c - "0");
            code = v > 127 ? 127 : v;
          end else esc_phase = actt_pkg::PH_BAD;
        end
        esc_count++;
      end
    end else if (c == actt_pkg::ESC_BYTE) begin
      esc_on = 1; esc_count = 0; esc_phase = actt_pkg::PH_BRACKET; code = 0;
    end else begin
      if (c == 8'h0A || c == 8'h0D) begin
        cur_col = 0; cur_row++;
      end else if (c >= 32 && c <= 126) begin
        scr_char[cur_row*COLS+cur_col] = c[6:0];
        scr_color[cur_row*COLS+cur_col] = pen;
        cur_col++;
        r.wrote = 1; r.ch = c[6:0]; r.color = pen;
      end
      if (cur_col >= COLS) begin
        cur_col = 0; cur_row++;
      end
      if (cur_row >= ROWS) begin
        for (int i = 0; i < (ROWS-1)*COLS; i++) begin
          scr_char[i] = scr_char[i+COLS];
          scr_color[i] = scr_color[i+COLS];
        end
        for (int j = 0; j < COLS; j++) begin
          scr_char[(ROWS-1)*COLS+j] = actt_pkg::SPACE_CHAR;
          scr_color[(ROWS-1)*COLS+j] = actt_pkg::DEFAULT_COLOR;
        end
        cur_row--;
        r.scrolled = 1;
      end
    end
    r.row = 4'(cur_row);
    r.col = 6'(cur_col);
    r.esc = esc_on;
    return r;
  endfunction

  always @(posedge clk) begin
    cell_result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < ROWS*COLS; i++) begin
        scr_char[i] = actt_pkg::SPACE_CHAR;
        scr_color[i] = actt_pkg::DEFAULT_COLOR;
      end
      cur_row = 0; cur_col = 0; esc_on = 0; esc_count = 0;
      esc_phase = actt_pkg::PH_BRACKET; code = 0; pen = actt_pkg::DEFAULT_COLOR;
      awaited.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        awaited.push_back(apply_request(in_tuser, in_tdata[7:0],
                                        int'(in_tdata[11:8]), int'(in_tdata[17:12])));
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[6:0], out_tdata[38:7], out_tdata[42:39],
               out_tdata[48:43], out_tdata[49], out_tdata[50]};
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected w%b ch%h col%h r%0d c%0d e%b s%b", $time,
                     want.wrote, want.ch, want.color, want.row, want.col, want.esc,
                     want.scrolled);
            $display("%0t:          actual   w%b ch%h col%h r%0d c%0d e%b s%b", $time,
                     got.wrote, got.ch, got.color, got.row, got.col, got.esc,
                     got.scrolled);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  // char_code[7:0], read_row[11:8], read_col[17:12], zero fill
  logic [23:0] in_tdata = '0;
  // op[0]
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  // cell_char[6:0], cell_color[38:7], crsr_row[42:39], crsr_col[48:43],
  // esc_open[49], scrolled[50], zero fill
  logic [55:0] out_tdata;
  // wrote_cell[0]
  logic        out_tuser;
  int          fail_count, pending;
  int          idle_cycles = 0;
  int          sent = 0;
  logic        calm = 0;    // last stretch of the run: no idling either side
  logic        hold_off = 0;  // long receiver stall to fill the pipeline
  logic        sender_busy = 1;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  ansi_color_text_terminal u_dut (.*);

  terminal_checker u_chk (.*);

  // watchdog: cycles with no accepted request on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 0;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 3);
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_request(input logic op, input logic [7:0] c,
                              input logic [3:0] rr, input logic [5:0] rc);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {6'd0, rc, rr, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_request(actt_pkg::OP_PUT, s[i], 4'($urandom), 6'($urandom));
  endtask

  task automatic put_sgr(input int n);
    send_request(actt_pkg::OP_PUT, actt_pkg::ESC_BYTE, 4'd0, 6'd0);
    put_text($sformatf("[%0dm", n));
  endtask

  task automatic read_cell(input int r, input int c);
    send_request(actt_pkg::OP_READ, 8'($urandom), 4'(r), 6'(c));
  endtask

  // sender pause until all results have drained
  task automatic drain;
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // random byte, biased towards printable text, newlines and sgr pieces
  function automatic logic [7:0] pick_byte;
    case ($urandom_range(0, 9))
      0: return 8'($urandom);
      1: return ($urandom_range(0, 1)) ? 8'h0A : 8'h0D;
      2: return 8'($urandom_range("0", "9"));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  initial begin
    int k, len;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // directed: colours, malformed and long sequences, extremes, reads
    put_text("A~ ");
    put_sgr(31); put_text("r");
    put_sgr(97); put_text("b");
    put_sgr(0); put_text("g");
    send_request(actt_pkg::OP_PUT, actt_pkg::ESC_BYTE, 4'd0, 6'd0);
    put_text("[999m");   // saturates, no change
    send_request(actt_pkg::OP_PUT, actt_pkg::ESC_BYTE, 4'd0, 6'd0);
    put_text("x32m");    // bad first byte
    send_request(actt_pkg::OP_PUT, actt_pkg::ESC_BYTE, 4'd0, 6'd0);
    put_text("[3;2K");   // bad digit, wrong letter
    send_request(actt_pkg::OP_PUT, actt_pkg::ESC_BYTE, 4'd0, 6'd0);
    put_text("[00000000000000032m"); // overlong
    send_request(actt_pkg::OP_PUT, 8'hFF, 4'd0, 6'd0);
    send_request(actt_pkg::OP_PUT, 8'h00, 4'd0, 6'd0);
    read_cell(0, 0); read_cell(15, 51); read_cell(15, 63); read_cell(0, 52);
    drain();

    // long receiver stall while the sender keeps going
    hold_off = 1;
    put_text("stall test line");
    drain();

    // random part: mostly text with sgr sequences, some noise and reads
    while (sent < 840) begin
      if (sent > 750) calm = 1;
      k = $urandom_range(0, 19);
      if (k == 0) begin
        put_sgr($urandom_range(0, 1) ? $urandom_range(30, 37) : $urandom_range(90, 97));
      end else if (k == 1) begin
        send_request(actt_pkg::OP_PUT, actt_pkg::ESC_BYTE, 4'd0, 6'd0);
        len = $urandom_range(0, 20);
        for (int i = 0; i < len; i++)
          send_request(actt_pkg::OP_PUT, pick_byte(), 4'd0, 6'd0);
        send_request(actt_pkg::OP_PUT,
                     8'($urandom_range(0, 1) ? "m" : $urandom_range("A", "Z")), 4'd0, 6'd0);
      end else if (k < 4) begin
        send_request(actt_pkg::OP_READ, 8'($urandom), 4'($urandom), 6'($urandom));
      end else if (k < 6) begin
        read_cell($urandom_range(0, 15), $urandom_range(0, 51));
      end else begin
        send_request(actt_pkg::OP_PUT, pick_byte(), 4'($urandom), 6'($urandom));
      end
    end
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
